// ----- design/ypcam_pkg.sv -----
package ypcam_pkg;

  localparam int HALF_TURN    = 11796480;
  localparam int FULL_TURN    = 23592960;
  localparam int QUARTER_TURN = 5898240;
  localparam int PITCH_LIMIT  = 5832704;
  localparam int INV_GAIN_Q30 = 652032874;
  localparam int RESET_YAW    = -5898240;
  localparam int RESET_SENS   = 6554;
  localparam int RESET_SPEED  = 163840;
  // ceil(2^27 / 45), exact quotient for dividends below 2^21
  localparam int WRAP_RECIP   = 2982617;
  localparam int WRAP_SHIFT   = 27;

  typedef enum logic [2:0] {
    CFG_SENS  = 3'd0,
    CFG_SPEED = 3'd1,
    CFG_YAW   = 3'd2,
    CFG_PITCH = 3'd3,
    CFG_POSX  = 3'd4,
    CFG_POSY  = 3'd5,
    CFG_POSZ  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic {
    KIND_KEY   = 1'b0,
    KIND_MOUSE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    NM_FRONT = 2'd0,
    NM_RIGHT = 2'd1,
    NM_UP    = 2'd2,
    NM_FLAT  = 2'd3
  } nmode_t;

  // atan(2^-i) in Q.16 degrees
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] clamp_pitch(input logic signed [41:0] a);
    logic signed [23:0] r;
    if (a > 42'(PITCH_LIMIT)) r = 24'(PITCH_LIMIT);
    else if (a < -42'(PITCH_LIMIT)) r = -24'(PITCH_LIMIT);
    else r = 24'(a);
    return r;
  endfunction

endpackage

// ----- design/yaw_pitch_camera_update.sv -----
// a key event runs no normalize (left/right) or one normalize (forward/back);
// a mouse event runs the yaw wrap, two cordic passes and three normalizes,
// each a 32-step root and three 64-step divides
// one event at a time; the next word is taken once the result register is loaded
// reset (rst, synchronous) loads the reset registers and rebuilds the basis
// before the first word is taken
module yaw_pitch_camera_update
  import ypcam_pkg::*;
#(
  parameter int TRIG_ITERATIONS  = 16,
  parameter int VECTOR_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // move_dir[1:0], delta_time[17:2], x_offset[49:18], y_offset[81:50]
  input  logic [87:0]  s_axis_tdata,
  // kind[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z (32b each), then front_x/y/z, right_x/y/z, up_x/y/z (16b each)
  output logic [239:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int BW      = VECTOR_FRAC_BITS + 2;
  localparam int SH      = (VECTOR_FRAC_BITS >= 14) ? VECTOR_FRAC_BITS - 14 : 0;
  localparam int UPS     = (VECTOR_FRAC_BITS < 14) ? 14 - VECTOR_FRAC_BITS : 0;
  localparam int RND_ADD = (SH == 0) ? 0 : (1 << (SH - 1));

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,
    S_MX     = 26'd1 << 1,
    S_MY     = 26'd1 << 2,
    S_MP     = 26'd1 << 3,
    S_WSTART = 26'd1 << 4,
    S_WRAP   = 26'd1 << 5,
    S_CINIT  = 26'd1 << 6,
    S_CROT   = 26'd1 << 7,
    S_FX     = 26'd1 << 8,
    S_FZ     = 26'd1 << 9,
    S_FZ2    = 26'd1 << 10,
    S_U0     = 26'd1 << 11,
    S_U1     = 26'd1 << 12,
    S_U2     = 26'd1 << 13,
    S_U3     = 26'd1 << 14,
    S_U4     = 26'd1 << 15,
    S_NSQ    = 26'd1 << 16,
    S_NSQRT  = 26'd1 << 17,
    S_NDIVST = 26'd1 << 18,
    S_NDIV   = 26'd1 << 19,
    S_NFIN   = 26'd1 << 20,
    S_KVEL   = 26'd1 << 21,
    S_KVEL2  = 26'd1 << 22,
    S_KMOVE  = 26'd1 << 23,
    S_OUT    = 26'd1 << 24,
    S_SPARE  = 26'd1 << 25
  } state_t;

  state_t state;

  logic [23:0]        sens, speed;
  logic signed [24:0] yaw;
  logic signed [23:0] pitch;
  logic signed [41:0] yaw_acc;
  logic signed [31:0] pos [3];
  logic signed [BW-1:0] basis [9];

  logic               emit, phase, cneg;
  logic [5:0]         cnt;
  logic [1:0]         nk;
  nmode_t             nmode;
  logic [4:0]         nfrac;

  logic [1:0]         dir;
  logic [15:0]        dt;
  logic signed [31:0] xo, yo;

  logic signed [33:0] cx, cyv;
  logic signed [26:0] cz;
  logic signed [33:0] cos_y, sin_y, cos_p, sin_p;
  logic signed [31:0] fx, fz;
  logic signed [31:0] a [3];
  logic signed [31:0] nv [3];
  logic signed [31:0] vec [3];
  logic signed [67:0] uacc;
  logic [32:0]        vel;

  logic [63:0]        sum_sq, sq_s, sq_res;
  logic [32:0]        len;
  logic [63:0]        dvd, quo;
  logic [33:0]        rem, dvs;

  logic signed [41:0] w_t, w_mag, w_res;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;

  // shared multiplier, one product a cycle
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  logic signed [31:0] a_sel, vec_sel, pos_sel;
  logic [31:0]        m_sel;

  always_comb begin
    unique case (nk)
      2'd0: begin a_sel = a[0]; vec_sel = vec[0]; end
      2'd1: begin a_sel = a[1]; vec_sel = vec[1]; end
      default: begin a_sel = a[2]; vec_sel = vec[2]; end
    endcase
    unique case (nk)
      2'd1: pos_sel = pos[0];
      2'd2: pos_sel = pos[1];
      default: pos_sel = pos[2];
    endcase
    m_sel = a_sel[31] ? 32'(-a_sel) : a_sel;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MX:  begin ma = 34'(xo); mb = {10'b0, sens}; end
      S_MY:  begin ma = 34'(yo); mb = {10'b0, sens}; end
      S_WSTART: begin ma = 34'(w_mag[39:19]); mb = 34'(WRAP_RECIP); end
      S_FX:  begin ma = cos_y; mb = cos_p; end
      S_FZ:  begin ma = sin_y; mb = cos_p; end
      S_U0:  begin ma = 34'(fx); mb = sin_p; end
      S_U1:  begin ma = 34'(fx); mb = 34'(fx); end
      S_U2:  begin ma = 34'(fz); mb = 34'(fz); end
      S_U3:  begin ma = 34'(fz); mb = sin_p; end
      S_NSQ: begin
        if (nk != 2'd3) begin
          ma = 34'(a_sel);
          mb = 34'(a_sel);
        end
      end
      S_KVEL: begin ma = {10'b0, speed}; mb = {18'b0, dt}; end
      S_KMOVE: begin
        if (nk != 2'd3) begin
          ma = {1'b0, vel};
          mb = 34'(vec_sel);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  logic signed [67:0] prod_r16, prod_r30, up_y_r30;
  assign prod_r16 = (prod + 68'sd32768) >>> 16;
  assign prod_r30 = (prod + (68'sd1 <<< 29)) >>> 30;
  assign up_y_r30 = (uacc + prod + (68'sd1 <<< 29)) >>> 30;

  // cordic rotation step
  logic signed [33:0] xs, ys, cx_n, cy_n;
  logic signed [26:0] cz_n;
  logic [21:0]        at;
  always_comb begin
    xs = cx >>> cnt[4:0];
    ys = cyv >>> cnt[4:0];
    at = atan_deg(cnt[4:0]);
    if (cz >= 0) begin
      cx_n = cx - ys;
      cy_n = cyv + xs;
      cz_n = cz - 27'(at);
    end else begin
      cx_n = cx + ys;
      cy_n = cyv - xs;
      cz_n = cz + 27'(at);
    end
  end

  logic signed [26:0] c_ang;
  assign c_ang = phase ? 27'(pitch) : 27'(yaw);

  // restoring divide step
  logic [33:0] rem_sh, rem_n;
  logic [63:0] quo_n;
  logic        div_ge;
  always_comb begin
    rem_sh = {rem[32:0], dvd[63]};
    div_ge = rem_sh >= dvs;
    rem_n  = div_ge ? rem_sh - dvs : rem_sh;
    quo_n  = {quo[62:0], div_ge};
  end

  // integer square root step
  logic [63:0] sq_bit, sq_t, sq_s_n, sq_res_n;
  always_comb begin
    sq_bit = 64'd1 << (6'd62 - {cnt[4:0], 1'b0});
    sq_t   = sq_res + sq_bit;
    if (sq_s >= sq_t) begin
      sq_s_n   = sq_s - sq_t;
      sq_res_n = (sq_res >> 1) + sq_bit;
    end else begin
      sq_s_n   = sq_s;
      sq_res_n = sq_res >> 1;
    end
  end

  // yaw wrap into [-180,180): a full turn is 45 << 19, so the low 19 bits
  // pass through and the upper part is reduced mod 45 by a reciprocal multiply
  logic [20:0] w_n;
  logic [15:0] w_q;
  logic [21:0] w_q45;
  logic [24:0] w_rem;
  always_comb begin
    w_t   = yaw_acc + 42'(HALF_TURN);
    w_mag = w_t[41] ? -w_t : w_t;
    w_n   = w_mag[39:19];
    w_q   = prod[WRAP_SHIFT +: 16];
    w_q45 = (22'(w_q) << 5) + (22'(w_q) << 3) + (22'(w_q) << 2) + 22'(w_q);
    w_rem = {6'(22'(w_n) - w_q45), w_mag[18:0]};
    if (!w_t[41]) w_res = 42'(w_rem);
    else if (w_rem == '0) w_res = '0;
    else w_res = 42'(FULL_TURN) - 42'(w_rem);
  end

  // normalize quotient with clamp and sign
  logic [63:0]        q_lim, q_cl;
  logic signed [31:0] q_sgn;
  always_comb begin
    q_lim = 64'd1 << nfrac;
    q_cl  = (quo_n > q_lim) ? q_lim : quo_n;
    q_sgn = a_sel[31] ? -32'(q_cl) : 32'(q_cl);
  end

  // position step
  logic [5:0]         k_sh;
  logic signed [67:0] k_step;
  logic signed [69:0] k_sum;
  logic signed [31:0] k_sat;
  always_comb begin
    k_sh   = 6'd8 + {1'b0, nfrac};
    k_step = (prod + (68'sd1 <<< (k_sh - 6'd1))) >>> k_sh;
    k_sum  = 70'(pos_sel) + 70'(k_step);
    if (k_sum > 70'sd2147483647) k_sat = 32'sh7fffffff;
    else if (k_sum < -70'sd2147483648) k_sat = 32'sh80000000;
    else k_sat = 32'(k_sum);
  end

  function automatic logic [15:0] to_q14(input logic signed [BW-1:0] v);
    logic signed [47:0] w;
    logic signed [15:0] r;
    w = (48'(v) <<< UPS);
    w = (w + 48'(RND_ADD)) >>> SH;
    if (w > 48'sd16384) r = 16'sd16384;
    else if (w < -48'sd16384) r = -16'sd16384;
    else r = 16'(w);
    return r;
  endfunction

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CINIT;
      phase         <= 1'b0;
      emit          <= 1'b0;
      cnt           <= '0;
      nk            <= '0;
      m_axis_tvalid <= 1'b0;
      sens          <= 24'(RESET_SENS);
      speed         <= 24'(RESET_SPEED);
      yaw           <= 25'(RESET_YAW);
      pitch         <= '0;
      pos[0]        <= '0;
      pos[1]        <= '0;
      pos[2]        <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dir  <= s_axis_tdata[1:0];
            dt   <= s_axis_tdata[17:2];
            xo   <= s_axis_tdata[49:18];
            yo   <= s_axis_tdata[81:50];
            emit <= 1'b1;
            state <= (s_axis_tuser[0] == KIND_MOUSE) ? S_MX : S_KVEL;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          yaw_acc <= 42'(yaw) + 42'(prod_r16);
          state   <= S_MP;
        end
        S_MP: begin
          pitch <= clamp_pitch(42'(pitch) + 42'(prod_r16));
          state <= S_WSTART;
        end
        S_WSTART: state <= S_WRAP;
        S_WRAP: begin
          yaw   <= 25'(w_res - 42'(HALF_TURN));
          phase <= 1'b0;
          state <= S_CINIT;
        end
        S_CINIT: begin
          cx  <= 34'(INV_GAIN_Q30);
          cyv <= '0;
          cnt <= '0;
          if (c_ang > 27'(QUARTER_TURN)) begin
            cz <= c_ang - 27'(HALF_TURN);
            cneg <= 1'b1;
          end else if (c_ang < -27'(QUARTER_TURN)) begin
            cz <= c_ang + 27'(HALF_TURN);
            cneg <= 1'b1;
          end else begin
            cz <= c_ang;
            cneg <= 1'b0;
          end
          state <= S_CROT;
        end
        S_CROT: begin
          cx  <= cx_n;
          cyv <= cy_n;
          cz  <= cz_n;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(TRIG_ITERATIONS - 1)) begin
            if (!phase) begin
              cos_y <= cneg ? -cx_n : cx_n;
              sin_y <= cneg ? -cy_n : cy_n;
              phase <= 1'b1;
              state <= S_CINIT;
            end else begin
              cos_p <= cneg ? -cx_n : cx_n;
              sin_p <= cneg ? -cy_n : cy_n;
              state <= S_FX;
            end
          end
        end
        S_FX: state <= S_FZ;
        S_FZ: begin
          fx    <= 32'(prod_r30);
          state <= S_FZ2;
        end
        S_FZ2: begin
          fz    <= 32'(prod_r30);
          a[0]  <= fx;
          a[1]  <= 32'(sin_p);
          a[2]  <= 32'(prod_r30);
          nmode <= NM_FRONT;
          nfrac <= 5'(VECTOR_FRAC_BITS);
          nk    <= '0;
          state <= S_NSQ;
        end
        S_U0: state <= S_U1;
        S_U1: begin
          a[0]  <= -32'(prod_r30);
          state <= S_U2;
        end
        S_U2: begin
          uacc  <= prod;
          state <= S_U3;
        end
        S_U3: begin
          a[1]  <= 32'(up_y_r30);
          state <= S_U4;
        end
        S_U4: begin
          a[2]  <= -32'(prod_r30);
          nmode <= NM_UP;
          nk    <= '0;
          state <= S_NSQ;
        end
        S_NSQ: begin
          if (nk == 2'd0) sum_sq <= '0;
          else sum_sq <= sum_sq + prod[63:0];
          if (nk == 2'd3) begin
            sq_s   <= sum_sq + prod[63:0];
            sq_res <= '0;
            cnt    <= '0;
            state  <= S_NSQRT;
          end else begin
            nk <= nk + 2'd1;
          end
        end
        S_NSQRT: begin
          sq_s   <= sq_s_n;
          sq_res <= sq_res_n;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            len   <= 33'(sq_res_n);
            nk    <= '0;
            state <= S_NDIVST;
          end
        end
        S_NDIVST: begin
          if (len == '0) begin
            nv[nk] <= '0;
            nk     <= nk + 2'd1;
            if (nk == 2'd2) state <= S_NFIN;
          end else begin
            dvd   <= ({32'b0, m_sel} << nfrac) + 64'(len >> 1);
            dvs   <= 34'(len);
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= S_NDIV;
          end
        end
        S_NDIV: begin
          rem <= rem_n;
          quo <= quo_n;
          dvd <= dvd << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            nv[nk] <= q_sgn;
            nk     <= nk + 2'd1;
            state  <= (nk == 2'd2) ? S_NFIN : S_NDIVST;
          end
        end
        S_NFIN: begin
          nk <= '0;
          unique case (nmode)
            NM_FRONT: begin
              basis[0] <= BW'(nv[0]);
              basis[1] <= BW'(nv[1]);
              basis[2] <= BW'(nv[2]);
              a[0]     <= -fz;
              a[1]     <= '0;
              a[2]     <= fx;
              nmode    <= NM_RIGHT;
              state    <= S_NSQ;
            end
            NM_RIGHT: begin
              basis[3] <= BW'(nv[0]);
              basis[4] <= BW'(nv[1]);
              basis[5] <= BW'(nv[2]);
              state    <= S_U0;
            end
            NM_UP: begin
              basis[6] <= BW'(nv[0]);
              basis[7] <= BW'(nv[1]);
              basis[8] <= BW'(nv[2]);
              state    <= emit ? S_OUT : S_IDLE;
            end
            default: begin
              for (int k = 0; k < 3; k++) begin
                vec[k] <= (dir == DIR_BACK) ? -nv[k] : nv[k];
              end
              state <= S_KMOVE;
            end
          endcase
        end
        S_KVEL: state <= S_KVEL2;
        S_KVEL2: begin
          vel <= 33'((prod + 68'sd128) >>> 8);
          nk  <= '0;
          if (dir == DIR_FWD || dir == DIR_BACK) begin
            a[0]  <= 32'(basis[0]);
            a[1]  <= '0;
            a[2]  <= 32'(basis[2]);
            nmode <= NM_FLAT;
            nfrac <= 5'd30;
            state <= S_NSQ;
          end else begin
            for (int k = 0; k < 3; k++) begin
              vec[k] <= (dir == DIR_LEFT) ? -32'(basis[3 + k]) : 32'(basis[3 + k]);
            end
            nfrac <= 5'(VECTOR_FRAC_BITS);
            state <= S_KMOVE;
          end
        end
        S_KMOVE: begin
          if (nk != 2'd0) begin
            unique case (nk)
              2'd1: pos[0] <= k_sat;
              2'd2: pos[1] <= k_sat;
              default: pos[2] <= k_sat;
            endcase
          end
          if (nk == 2'd3) state <= S_OUT;
          else nk <= nk + 2'd1;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {to_q14(basis[8]), to_q14(basis[7]), to_q14(basis[6]),
                              to_q14(basis[5]), to_q14(basis[4]), to_q14(basis[3]),
                              to_q14(basis[2]), to_q14(basis[1]), to_q14(basis[0]),
                              pos[2], pos[1], pos[0]};
            emit  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // start values load the state directly; angle writes rebuild the basis
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENS:  sens  <= cfg_data[23:0];
          CFG_SPEED: speed <= cfg_data[23:0];
          CFG_YAW: begin
            yaw_acc <= {{17{cfg_data[24]}}, cfg_data[24:0]};
            emit    <= 1'b0;
            state   <= S_WSTART;
          end
          CFG_PITCH: begin
            pitch <= clamp_pitch({{18{cfg_data[23]}}, cfg_data[23:0]});
            phase <= 1'b0;
            emit  <= 1'b0;
            state <= S_CINIT;
          end
          CFG_POSX: pos[0] <= cfg_data;
          CFG_POSY: pos[1] <= cfg_data;
          CFG_POSZ: pos[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_word: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block took a word while still busy");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    pitch <= 24'(PITCH_LIMIT) && pitch >= -24'(PITCH_LIMIT))
    else $error("pitch outside limit");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    yaw >= -25'(HALF_TURN) && 26'(yaw) < 26'(HALF_TURN))
    else $error("yaw not wrapped");

  a_cordic_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CROT |-> cnt < 6'(TRIG_ITERATIONS))
    else $error("cordic ran past its iterations");
`endif

endmodule
